// ----- hdl/tstrip_pkg.sv -----
// Shared types and constants for the subtitle tag stripper.
// Holds character codes, tag position rules and the controller/datapath
// command and status structs. No dependencies.
package tstrip_pkg;

  // Character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_U     = 8'h75;

  // Tag position rules
  localparam int TAG_OPEN_LEN   = 3;   // <b? <i? <u?
  localparam int TAG_CLOSE_LEN  = 4;   // </b? </i? </u?
  localparam int FONT_CLOSE_LEN = 7;   // </f????
  localparam int FONT_ATTR_POS  = 5;   // first attribute slot after <f???
  localparam int COLOR_SKIP     = 15;  // 'c' plus 14 unchecked bytes
  localparam int SIZE_SKIP      = 6;   // 's' plus 5 unchecked bytes

  typedef struct packed {
    logic accept;      // input word taken this cycle
    logic walk_start;  // read front entry, clear scan trackers
    logic walk_ev;     // evaluate the entry just read
    logic resolve;     // commit the judged action
    logic flush;       // send held word as last of its run
  } tstrip_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic walk_more;
    logic res_stop;
    logic res_emit;
    logic res_left_zero;
    logic held_valid;
    logic out_free;
  } tstrip_sts_t;

  function automatic logic is_biu(logic [7:0] c);
    return (c == CH_B) || (c == CH_I) || (c == CH_U);
  endfunction

endpackage

// ----- hdl/tstrip_if.sv -----
// Valid/ready channel interfaces for the subtitle tag stripper.
// Input carries one raw text byte, output one stripped byte with flags.
// No dependencies.
interface tstrip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface tstrip_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] kept_byte;
  logic       phrase_end;
  logic       run_last;

  modport source (output valid, output kept_byte, output phrase_end, output run_last,
                  input ready);
  modport sink   (input valid, input kept_byte, input phrase_end, input run_last,
                  output ready);
endinterface

// ----- hdl/tstrip_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tstrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tstrip_dp.sv -----
// Datapath of the subtitle tag stripper: pending byte buffer (circular RAM),
// tag scan trackers, held result and output register.
// Depends on tstrip_pkg and tstrip_ram.
module tstrip_dp import tstrip_pkg::*; #(
  parameter int MAX_TAG = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tstrip_cmd_t cmd_i,
  output tstrip_sts_t sts_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_end_o,
  output logic        out_last_o
);

  localparam int PW    = $clog2(MAX_TAG);
  localparam int CW    = $clog2(MAX_TAG + 1);
  localparam int KW    = $clog2(MAX_TAG + COLOR_SKIP);
  localparam int DEPTH = 2 ** PW;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TAG);

  localparam logic [2:0] PS_FIRST = 3'd0;
  localparam logic [2:0] PS_SLASH = 3'd1;
  localparam logic [2:0] PS_ATTR  = 3'd2;
  localparam logic [2:0] PS_SEL   = 3'd3;
  localparam logic [2:0] PS_DIGIT = 3'd4;

  // Buffer control
  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] waddr, raddr;
  logic          ram_we;
  logic [7:0]    rbyte;

  // Scan trackers
  logic [PW-1:0] p_q, p_d;
  logic [7:0]    front_q, front_d;
  logic          second_lf_q, second_lf_d;
  logic [2:0]    ps_q, ps_d;
  logic [KW-1:0] tk_q, tk_d;
  logic          done_q, done_d;
  logic [KW-1:0] r_q, r_d;
  logic          lf_found_q, lf_found_d;
  logic [PW-1:0] e_q, e_d;
  logic          prev_cr_q, prev_cr_d;
  logic          last_cr_q, last_cr_d;

  // Result staging
  logic          held_v_q, held_v_d;
  logic [7:0]    held_byte_q, held_byte_d;
  logic          held_end_q, held_end_d;
  logic          out_v_q, out_v_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_end_q, out_end_d;
  logic          out_last_q, out_last_d;

  // Walk and resolve
  logic [KW-1:0] p_ext, n_ext, e_ext;
  logic [CW-1:0] p_next;
  logic          is_lt, walk_more;
  logic          res_stop, res_emit, res_end, res_reject;
  logic [7:0]    res_byte;
  logic [CW-1:0] res_drop;
  logic          fast, store, emit_commit, load_out, out_free;

  assign waddr  = head_q + count_q[PW-1:0];
  assign raddr  = head_q + (cmd_i.walk_start ? '0 : p_q);

  tstrip_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (in_byte_i),
    .raddr_i (raddr),
    .rdata_o (rbyte)
  );

  assign p_ext  = KW'(p_q);
  assign n_ext  = KW'(count_q);
  assign e_ext  = KW'(e_q);
  assign p_next = CW'(p_q) + CW'(1);

  // Keep walking the whole candidate for a tag, one extra entry for a CR
  always_comb begin
    is_lt     = (p_q == '0) ? (rbyte == CH_LT) : (front_q == CH_LT);
    walk_more = (is_lt && (p_next < count_q)) ||
                ((p_q == '0) && (rbyte == CH_CR) && (count_q >= CW'(2)));
  end

  // Tag rule parser and line-end trackers
  always_comb begin
    p_d         = p_q;
    front_d     = front_q;
    second_lf_d = second_lf_q;
    ps_d        = ps_q;
    tk_d        = tk_q;
    done_d      = done_q;
    r_d         = r_q;
    lf_found_d  = lf_found_q;
    e_d         = e_q;
    prev_cr_d   = prev_cr_q;
    last_cr_d   = last_cr_q;
    if (cmd_i.walk_start) begin
      p_d        = '0;
      ps_d       = PS_FIRST;
      tk_d       = KW'(1);
      done_d     = 1'b0;
      r_d        = '0;
      lf_found_d = 1'b0;
      prev_cr_d  = 1'b0;
    end else if (cmd_i.walk_ev) begin
      p_d       = p_q + PW'(1);
      prev_cr_d = (rbyte == CH_CR);
      last_cr_d = (rbyte == CH_CR);
      if (p_q == '0) begin
        front_d = rbyte;
      end
      if (p_q == PW'(1)) begin
        second_lf_d = (rbyte == CH_LF);
      end
      // First line end: a CR right before the LF moves it back one place
      if (!lf_found_q && (rbyte == CH_LF)) begin
        lf_found_d = 1'b1;
        e_d        = prev_cr_q ? (p_q - PW'(1)) : p_q;
      end
      if (!done_q && (p_ext == tk_q)) begin
        case (ps_q)
          PS_FIRST: begin
            if (rbyte == CH_SLASH) begin
              ps_d = PS_SLASH;
              tk_d = p_ext + KW'(1);
            end else if (is_biu(rbyte)) begin
              done_d = 1'b1;
              r_d    = KW'(TAG_OPEN_LEN);
            end else if (rbyte == CH_F) begin
              ps_d = PS_ATTR;
              tk_d = KW'(FONT_ATTR_POS);
            end else begin
              done_d = 1'b1;
              r_d    = '0;
            end
          end
          PS_SLASH: begin
            done_d = 1'b1;
            if (is_biu(rbyte)) begin
              r_d = KW'(TAG_CLOSE_LEN);
            end else if (rbyte == CH_F) begin
              r_d = KW'(FONT_CLOSE_LEN);
            end else begin
              r_d = '0;
            end
          end
          PS_ATTR: begin
            if (rbyte == CH_SP) begin
              ps_d = PS_SEL;
              tk_d = p_ext + KW'(1);
            end else begin
              done_d = 1'b1;
              r_d    = (rbyte == CH_GT) ? (p_ext + KW'(1)) : '0;
            end
          end
          PS_SEL: begin
            if (rbyte == CH_C) begin
              ps_d = PS_ATTR;
              tk_d = p_ext + KW'(COLOR_SKIP);
            end else if (rbyte == CH_S) begin
              ps_d = PS_DIGIT;
              tk_d = p_ext + KW'(SIZE_SKIP);
            end else begin
              done_d = 1'b1;
              r_d    = (rbyte == CH_GT) ? (p_ext + KW'(1)) : '0;
            end
          end
          PS_DIGIT: begin
            tk_d = p_ext + KW'(1);
            if ((rbyte < CH_0) || (rbyte > CH_9)) begin
              ps_d = PS_ATTR;
            end
          end
          default: begin
            done_d = 1'b1;
            r_d    = '0;
          end
        endcase
      end
    end
  end

  // Judge the front entry from the finished walk
  always_comb begin
    res_stop   = 1'b0;
    res_reject = 1'b0;
    res_emit   = 1'b0;
    res_end    = 1'b0;
    res_byte   = front_q;
    res_drop   = CW'(1);
    if (front_q == CH_LT) begin
      if (done_q && (r_q == '0)) begin
        res_reject = 1'b1;
      end else if (done_q && (r_q <= n_ext)) begin
        if (lf_found_q && (e_ext < r_q)) begin
          res_reject = 1'b1;
        end else if (!lf_found_q && last_cr_q && (r_q == n_ext)) begin
          res_stop = 1'b1;
        end else begin
          res_drop = CW'(r_q);
        end
      end else if (lf_found_q || (count_q >= MAX_CNT)) begin
        res_reject = 1'b1;
      end else begin
        res_stop = 1'b1;
      end
      if (res_reject) begin
        res_emit = 1'b1;
        res_byte = CH_LT;
      end
    end else if (front_q == CH_CR) begin
      if (count_q < CW'(2)) begin
        res_stop = 1'b1;
      end else if (second_lf_q) begin
        res_emit = 1'b1;
        res_end  = 1'b1;
        res_byte = CH_LF;
        res_drop = CW'(2);
      end else begin
        res_emit = 1'b1;
      end
    end else begin
      res_emit = 1'b1;
      res_end  = (front_q == CH_LF);
    end
  end

  // Buffer bookkeeping and result staging
  always_comb begin
    out_free    = !out_v_q || out_ready_i;
    fast        = cmd_i.accept && (count_q == '0) &&
                  (in_byte_i != CH_LT) && (in_byte_i != CH_CR);
    store       = cmd_i.accept && !fast && (count_q < MAX_CNT);
    ram_we      = store;
    emit_commit = cmd_i.resolve && res_emit;
    load_out    = fast || (emit_commit && held_v_q) || cmd_i.flush;

    head_d  = head_q;
    count_d = count_q;
    if (store) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.resolve) begin
      count_d = count_q - res_drop;
      head_d  = head_q + res_drop[PW-1:0];
    end

    held_v_d    = held_v_q;
    held_byte_d = held_byte_q;
    held_end_d  = held_end_q;
    if (emit_commit) begin
      held_v_d    = 1'b1;
      held_byte_d = res_byte;
      held_end_d  = res_end;
    end else if (cmd_i.flush) begin
      held_v_d = 1'b0;
    end

    out_v_d    = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_v_q);
    out_byte_d = out_byte_q;
    out_end_d  = out_end_q;
    out_last_d = out_last_q;
    if (fast) begin
      out_byte_d = in_byte_i;
      out_end_d  = (in_byte_i == CH_LF);
      out_last_d = 1'b1;
    end else if (load_out) begin
      out_byte_d = held_byte_q;
      out_end_d  = held_end_q;
      out_last_d = cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      held_v_q <= held_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    front_q     <= front_d;
    second_lf_q <= second_lf_d;
    ps_q        <= ps_d;
    tk_q        <= tk_d;
    done_q      <= done_d;
    r_q         <= r_d;
    lf_found_q  <= lf_found_d;
    e_q         <= e_d;
    prev_cr_q   <= prev_cr_d;
    last_cr_q   <= last_cr_d;
    held_byte_q <= held_byte_d;
    held_end_q  <= held_end_d;
    out_byte_q  <= out_byte_d;
    out_end_q   <= out_end_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    sts_o.count_zero    = (count_q == '0);
    sts_o.walk_more     = walk_more;
    sts_o.res_stop      = res_stop;
    sts_o.res_emit      = res_emit;
    sts_o.res_left_zero = (count_q == res_drop);
    sts_o.held_valid    = held_v_q;
    sts_o.out_free      = out_free;
  end

  assign out_valid_o = out_v_q;
  assign out_byte_o  = out_byte_q;
  assign out_end_o   = out_end_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- hdl/tstrip_ctrl.sv -----
// Controller of the subtitle tag stripper: sequences accept, buffer walk,
// resolve and end-of-run flush. Depends on tstrip_pkg.
module tstrip_ctrl import tstrip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tstrip_sts_t sts_i,
  output tstrip_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FRONT_RD = 3'd1;
  localparam logic [2:0] S_WALK_EV  = 3'd2;
  localparam logic [2:0] S_WALK_RD  = 3'd3;
  localparam logic [2:0] S_RESOLVE  = 3'd4;
  localparam logic [2:0] S_END      = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = sts_i.out_free;
        cmd_o.accept = in_valid_i && sts_i.out_free;
        // An empty buffer needs no walk (fast path, or the byte waits); otherwise rescan from the front
        if (cmd_o.accept && !sts_i.count_zero) begin
          state_d = S_FRONT_RD;
        end
      end
      S_FRONT_RD: begin
        cmd_o.walk_start = 1'b1;
        state_d          = S_WALK_EV;
      end
      S_WALK_EV: begin
        cmd_o.walk_ev = 1'b1;
        state_d       = sts_i.walk_more ? S_WALK_RD : S_RESOLVE;
      end
      S_WALK_RD: begin
        state_d = S_WALK_EV;
      end
      S_RESOLVE: begin
        if (sts_i.res_stop) begin
          state_d = S_END;
        end else if (!(sts_i.res_emit && sts_i.held_valid && !sts_i.out_free)) begin
          cmd_o.resolve = 1'b1;
          state_d       = sts_i.res_left_zero ? S_END : S_FRONT_RD;
        end
      end
      S_END: begin
        if (!sts_i.held_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/subtitle_tag_stripper_core.sv -----
// Empty buffer, byte not '<' or CR: the result is registered into the output
// register on acceptance, up to one word per cycle while the output is free.
// Otherwise the front entry is read, the pending buffer (up to MAX_TAG entries)
// is walked from one RAM read port (read, then evaluate, per entry) and the front
// is resolved; a full output register holds the resolve and the final flush.
// Asynchronous active-low reset empties the buffer and the output; no clear pass.
module subtitle_tag_stripper_core import tstrip_pkg::*; #(
  parameter int MAX_TAG = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tstrip_in_if.sink    text_i,
  tstrip_out_if.source kept_o
);

  tstrip_cmd_t cmd;
  tstrip_sts_t sts;

  tstrip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (text_i.valid),
    .in_ready_o (text_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tstrip_dp #(
    .MAX_TAG (MAX_TAG)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (text_i.text_byte),
    .out_valid_o (kept_o.valid),
    .out_ready_i (kept_o.ready),
    .out_byte_o  (kept_o.kept_byte),
    .out_end_o   (kept_o.phrase_end),
    .out_last_o  (kept_o.run_last)
  );

endmodule

// ----- test/subtitle_tag_stripper_core_tb.sv -----
// Testbench for subtitle_tag_stripper_core: drives raw subtitle bytes, predicts the
// stripped text in a scoreboard class and checks every kept word in order.
// Depends on tstrip_pkg and the channel interfaces in tstrip_if.
module subtitle_tag_stripper_core_tb;
  import tstrip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PEND_DEPTH   = 32;
  localparam int RANDOM_BYTES = 245;
  localparam int HOLD_CYCLES  = 400;
  localparam int LINGER       = 100;
  localparam int TIMEOUT_NS   = 5_000_000;

  // Tag position rules for the predictor
  localparam int STYLE_OPEN_LEN  = 3;
  localparam int STYLE_CLOSE_LEN = 4;
  localparam int FONT_END_LEN    = 7;
  localparam int FONT_ATTR_AT    = 5;
  localparam int COLOR_ATTR_SKIP = 15;
  localparam int SIZE_ATTR_SKIP  = 6;

  // Judgment codes for a pending tag candidate; a positive value is its length
  localparam int TAG_WAIT   = -1;
  localparam int TAG_REJECT = 0;

  typedef enum int {
    RUN_PLAIN, RUN_STYLE_OPEN, RUN_STYLE_CLOSE, RUN_FONT_CLOSE, RUN_FONT_OPEN,
    RUN_LINE_END, RUN_LONE_CR, RUN_BAD_TAG, RUN_SPLIT_TAG, RUN_LONG_TAG,
    RUN_NOISE, RUN_CUT_TAG, RUN_KINDS
  } run_kind_e;

  typedef struct packed {
    logic [7:0] kept_byte;
    logic       phrase_end;
    logic       run_last;
  } kept_word_t;

  class stripped_text_board;
    logic [7:0] tag_buf [PEND_DEPTH];
    int         tag_fill = 0;
    kept_word_t due_words [$];
    int fails = 0;
    int bytes_in = 0;
    int words_out = 0;
    int phrase_ends = 0;
    int tags_stripped = 0;
    int tags_rejected = 0;

    function int peek(int k);
      if (k < 0 || k >= tag_fill || k >= PEND_DEPTH) return TAG_WAIT;
      return int'(tag_buf[k]);
    endfunction

    function bit is_style(int c);
      return c == CH_B || c == CH_I || c == CH_U;
    endfunction

    // Tag length from the position rules alone
    function int rule_length();
      int c;
      int k;
      c = peek(1);
      if (c < 0) return TAG_WAIT;
      if (c == CH_SLASH) begin
        c = peek(2);
        if (c < 0) return TAG_WAIT;
        if (is_style(c)) return STYLE_CLOSE_LEN;
        if (c == CH_F) return FONT_END_LEN;
        return TAG_REJECT;
      end
      if (is_style(c)) return STYLE_OPEN_LEN;
      if (c != CH_F) return TAG_REJECT;
      k = FONT_ATTR_AT;
      c = peek(k);
      if (c < 0) return TAG_WAIT;
      while (c == CH_SP) begin
        k++;
        c = peek(k);
        if (c < 0) return TAG_WAIT;
        if (c == CH_C) begin
          k += COLOR_ATTR_SKIP;
        end else if (c == CH_S) begin
          k += SIZE_ATTR_SKIP;
          forever begin
            c = peek(k);
            if (c < 0) return TAG_WAIT;
            if (c < CH_0 || c > CH_9) break;
            k++;
          end
          k++;
        end else if (c != CH_GT) begin
          return TAG_REJECT;
        end
        c = peek(k);
        if (c < 0) return TAG_WAIT;
      end
      return (c == CH_GT) ? k + 1 : TAG_REJECT;
    endfunction

    // Add line-end and capacity rules on top of the position rules
    function int judge_front();
      int r;
      int n;
      r = rule_length();
      n = tag_fill;
      if (r > 0) begin
        if (r > n) begin
          r = TAG_WAIT;
        end else begin
          for (int j = 0; j < r; j++) begin
            if (tag_buf[j] == CH_LF) return TAG_REJECT;
            if (tag_buf[j] == CH_CR) begin
              if (j + 1 >= n) return TAG_WAIT;
              if (tag_buf[j + 1] == CH_LF) return TAG_REJECT;
            end
          end
        end
      end
      if (r == TAG_WAIT) begin
        for (int j = 1; j < n; j++)
          if (tag_buf[j] == CH_LF) return TAG_REJECT;
        if (n >= PEND_DEPTH) return TAG_REJECT;
      end
      return r;
    endfunction

    function void drop_front(int k);
      if (k >= tag_fill) begin
        tag_fill = 0;
        return;
      end
      for (int i = 0; i < tag_fill - k; i++) tag_buf[i] = tag_buf[i + k];
      tag_fill -= k;
    endfunction

    function void add_word(logic [7:0] b, logic pe);
      kept_word_t w;
      w.kept_byte  = b;
      w.phrase_end = pe;
      w.run_last   = 1'b0;
      due_words.push_back(w);
    endfunction

    // Take one accepted text byte and queue the words it releases
    function void strip_byte(logic [7:0] b);
      int         first;
      int         r;
      logic [7:0] f;
      kept_word_t w;
      first = due_words.size();
      bytes_in++;
      if (tag_fill < PEND_DEPTH) begin
        tag_buf[tag_fill] = b;
        tag_fill++;
      end
      while (tag_fill > 0) begin
        f = tag_buf[0];
        if (f == CH_LT) begin
          r = judge_front();
          if (r == TAG_WAIT) break;
          if (r == TAG_REJECT) begin
            add_word(CH_LT, 1'b0);
            drop_front(1);
            tags_rejected++;
          end else begin
            drop_front(r);
            tags_stripped++;
          end
        end else if (f == CH_CR) begin
          if (tag_fill < 2) break;
          if (tag_buf[1] == CH_LF) begin
            add_word(CH_LF, 1'b1);
            drop_front(2);
          end else begin
            add_word(CH_CR, 1'b0);
            drop_front(1);
          end
        end else if (f == CH_LF) begin
          add_word(CH_LF, 1'b1);
          drop_front(1);
        end else begin
          add_word(f, 1'b0);
          drop_front(1);
        end
      end
      if (due_words.size() > first) begin
        w = due_words.pop_back();
        w.run_last = 1'b1;
        due_words.push_back(w);
      end
    endfunction

    function void check_word(logic [7:0] kept_byte, logic phrase_end, logic run_last);
      kept_word_t w;
      if (due_words.size() == 0) begin
        $error("unexpected word: kept_byte %02h phrase_end %0b run_last %0b",
               kept_byte, phrase_end, run_last);
        fails++;
        return;
      end
      w = due_words.pop_front();
      words_out++;
      if (phrase_end) phrase_ends++;
      if (kept_byte !== w.kept_byte) begin
        $error("kept_byte: expected %02h, got %02h", w.kept_byte, kept_byte);
        fails++;
      end
      if (phrase_end !== w.phrase_end) begin
        $error("phrase_end: expected %0b, got %0b", w.phrase_end, phrase_end);
        fails++;
      end
      if (run_last !== w.run_last) begin
        $error("run_last: expected %0b, got %0b", w.run_last, run_last);
        fails++;
      end
    endfunction

    function int outstanding();
      return due_words.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tstrip_in_if  text_if ();
  tstrip_out_if kept_if ();

  subtitle_tag_stripper_core #(
    .MAX_TAG(PEND_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .text_i(text_if.sink),
    .kept_o(kept_if.source)
  );

  stripped_text_board board;
  logic [7:0]         seq_q [$];
  bit                 tx_idle = 1'b1;
  bit                 rx_idle = 1'b1;
  int                 rx_hold_len = 0;
  int                 rx_hold = 0;
  int                 rx_stall = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #TIMEOUT_NS;
    $display("FAIL");
    $finish;
  end

  // Note accepted bytes before checking words so the expectation order holds
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (text_if.valid && text_if.ready) board.strip_byte(text_if.text_byte);
      if (kept_if.valid && kept_if.ready)
        board.check_word(kept_if.kept_byte, kept_if.phrase_end, kept_if.run_last);
    end
  end

  // Output side: random back-pressure, plus one long hold-off on request
  initial begin
    kept_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_len > 0) begin
        rx_hold     = rx_hold_len;
        rx_hold_len = 0;
      end
      if (rx_hold > 0) begin
        kept_if.ready = 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        kept_if.ready = 1'b0;
        rx_stall--;
      end else if (!rx_idle || $urandom_range(0, 99) < 60) begin
        kept_if.ready = 1'b1;
      end else begin
        kept_if.ready = 1'b0;
        rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(0, 2);
      end
    end
  end

  task automatic send_text(input logic [7:0] b);
    int gap;
    gap = 0;
    if (tx_idle) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: gap = 0;
        19:                               gap = $urandom_range(8, 40);
        default:                          gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      @(negedge clk_i);
      text_if.valid     = 1'b0;
      text_if.text_byte = 8'($urandom_range(0, 255));
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    text_if.valid     = 1'b1;
    text_if.text_byte = b;
    do @(posedge clk_i); while (!text_if.ready);
  endtask

  task automatic wait_drained();
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] loose_byte();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] plain_non_digit();
    logic [7:0] b;
    do b = loose_byte(); while (b >= CH_0 && b <= CH_9);
    return b;
  endfunction

  function automatic logic [7:0] style_letter();
    case ($urandom_range(0, 2))
      0:       return CH_B;
      1:       return CH_I;
      default: return CH_U;
    endcase
  endfunction

  // Append one well-formed tag with random unchecked content
  function automatic void add_tag(run_kind_e kind);
    int attrs;
    int pick;
    case (kind)
      RUN_STYLE_OPEN: begin
        seq_q.push_back(CH_LT);
        seq_q.push_back(style_letter());
        seq_q.push_back(($urandom_range(0, 3) == 0) ? loose_byte() : CH_GT);
      end
      RUN_STYLE_CLOSE: begin
        seq_q.push_back(CH_LT);
        seq_q.push_back(CH_SLASH);
        seq_q.push_back(style_letter());
        seq_q.push_back(($urandom_range(0, 3) == 0) ? loose_byte() : CH_GT);
      end
      RUN_FONT_CLOSE: begin
        seq_q.push_back(CH_LT);
        seq_q.push_back(CH_SLASH);
        seq_q.push_back(CH_F);
        repeat (3) seq_q.push_back(loose_byte());
        seq_q.push_back(($urandom_range(0, 3) == 0) ? loose_byte() : CH_GT);
      end
      default: begin
        seq_q.push_back(CH_LT);
        seq_q.push_back(CH_F);
        repeat (3) seq_q.push_back(loose_byte());
        attrs = $urandom_range(0, 2);
        for (int a = 0; a < attrs; a++) begin
          seq_q.push_back(CH_SP);
          pick = $urandom_range(0, 4);
          // an empty attribute ends the tag at once
          if (pick == 0) break;
          if (pick <= 2) begin
            seq_q.push_back(CH_C);
            repeat (COLOR_ATTR_SKIP - 1) seq_q.push_back(loose_byte());
          end else begin
            seq_q.push_back(CH_S);
            repeat (SIZE_ATTR_SKIP - 1) seq_q.push_back(loose_byte());
            repeat ($urandom_range(0, 3)) seq_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
            seq_q.push_back(plain_non_digit());
          end
        end
        seq_q.push_back(CH_GT);
      end
    endcase
  endfunction

  function automatic void compose_run(run_kind_e kind);
    int spot;
    int cut;
    seq_q.delete();
    case (kind)
      RUN_PLAIN:
        repeat ($urandom_range(1, 6)) seq_q.push_back(loose_byte());
      RUN_STYLE_OPEN, RUN_STYLE_CLOSE, RUN_FONT_CLOSE, RUN_FONT_OPEN:
        add_tag(kind);
      RUN_LINE_END: begin
        if ($urandom_range(0, 1) == 1) seq_q.push_back(CH_CR);
        seq_q.push_back(CH_LF);
      end
      RUN_LONE_CR: begin
        seq_q.push_back(CH_CR);
        seq_q.push_back(loose_byte());
      end
      RUN_BAD_TAG: begin
        seq_q.push_back(CH_LT);
        if ($urandom_range(0, 1) == 1) seq_q.push_back(CH_SLASH);
        seq_q.push_back(loose_byte());
      end
      RUN_SPLIT_TAG: begin
        // put a line end, or a CR left waiting, inside a tag
        add_tag(run_kind_e'($urandom_range(RUN_STYLE_OPEN, RUN_FONT_OPEN)));
        spot = $urandom_range(1, seq_q.size() - 1);
        case ($urandom_range(0, 2))
          0: seq_q[spot] = CH_LF;
          1: begin
            seq_q[spot] = CH_CR;
            seq_q.insert(spot + 1, CH_LF);
          end
          default: seq_q[spot] = CH_CR;
        endcase
      end
      RUN_LONG_TAG: begin
        // size digits around the capacity boundary
        seq_q.push_back(CH_LT);
        seq_q.push_back(CH_F);
        repeat (3) seq_q.push_back(loose_byte());
        seq_q.push_back(CH_SP);
        seq_q.push_back(CH_S);
        repeat (SIZE_ATTR_SKIP - 1) seq_q.push_back(loose_byte());
        repeat ($urandom_range(16, 28)) seq_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
        seq_q.push_back(plain_non_digit());
        seq_q.push_back(CH_GT);
      end
      RUN_NOISE:
        repeat ($urandom_range(1, 4)) seq_q.push_back(8'($urandom_range(0, 255)));
      default: begin
        add_tag(run_kind_e'($urandom_range(RUN_STYLE_OPEN, RUN_FONT_OPEN)));
        cut = $urandom_range(1, seq_q.size() - 1);
        while (seq_q.size() > cut) void'(seq_q.pop_back());
        seq_q.push_back(loose_byte());
      end
    endcase
  endfunction

  initial begin
    int        bytes_sent;
    int        run_no;
    bit        held;
    bit        paused;
    run_kind_e kind;
    bytes_sent = 0;
    run_no     = 0;
    held       = 1'b0;
    paused     = 1'b0;
    board = new();
    rst_ni            = 1'b0;
    text_if.valid     = 1'b0;
    text_if.text_byte = 8'h00;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Field extremes, style and font close tags, line ends, a lone CR, rejected tags
    seq_q = {8'h00, 8'hFF, CH_LT, CH_B, CH_GT, CH_LT, CH_SLASH, CH_U, CH_GT,
             CH_CR, CH_LF, CH_CR, 8'h41, CH_LF, CH_LT, 8'h71,
             CH_LT, CH_I, CH_LF, CH_LT, CH_SLASH, CH_F, 8'h6F, 8'h6E, 8'h74, CH_GT};
    foreach (seq_q[i]) send_text(seq_q[i]);
    @(negedge clk_i);
    text_if.valid = 1'b0;
    wait_drained();

    while (bytes_sent < RANDOM_BYTES) begin
      if (!held && bytes_sent >= 90) begin
        // hold the output off while bytes keep coming
        rx_hold_len = HOLD_CYCLES;
        held = 1'b1;
      end
      if (!paused && bytes_sent >= 170) begin
        @(negedge clk_i);
        text_if.valid = 1'b0;
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if (run_no < RUN_KINDS) begin
        kind = run_kind_e'(run_no);
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:19]:  kind = RUN_PLAIN;
          [20:29]: kind = RUN_STYLE_OPEN;
          [30:39]: kind = RUN_STYLE_CLOSE;
          [40:46]: kind = RUN_FONT_CLOSE;
          [47:61]: kind = RUN_FONT_OPEN;
          [62:69]: kind = RUN_LINE_END;
          [70:73]: kind = RUN_LONE_CR;
          [74:78]: kind = RUN_BAD_TAG;
          [79:84]: kind = RUN_SPLIT_TAG;
          [85:87]: kind = RUN_LONG_TAG;
          [88:93]: kind = RUN_NOISE;
          default: kind = RUN_CUT_TAG;
        endcase
      end
      compose_run(kind);
      foreach (seq_q[i]) send_text(seq_q[i]);
      bytes_sent += seq_q.size();
      run_no++;
    end

    @(negedge clk_i);
    text_if.valid = 1'b0;
    wait_drained();
    repeat (LINGER) @(posedge clk_i);

    $display("Sent %0d text bytes, checked %0d kept words with %0d phrase ends.",
             board.bytes_in, board.words_out, board.phrase_ends);
    $display("Tags stripped %0d, rejected %0d; one %0d-cycle output hold, one input drain.",
             board.tags_stripped, board.tags_rejected, HOLD_CYCLES);
    if (board.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
